### hdl/avsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package avsc_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Register indices on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_IS_MASTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_COEF           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_SYNC_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION_PERCENT = 3'd5;

  // Register values after reset.
  localparam logic        RST_AUDIO_IS_MASTER    = 1'b0;
  localparam logic [18:0] RST_SOURCE_RATE        = 19'd44100;
  localparam logic [15:0] RST_AVG_COEF           = 16'd52057;
  localparam logic [30:0] RST_DIFF_THRESHOLD     = 31'd671089;
  localparam logic [30:0] RST_NO_SYNC_LIMIT      = 31'd167772160;
  localparam logic [6:0]  RST_CORRECTION_PERCENT = 7'd10;

  // Number of filtered frames before a correction may be made.
  localparam logic [4:0] AVG_WARMUP = 5'd20;

  // Bit-serial step counts: coefficient multiply, rate multiply, divide by a hundred.
  localparam logic [4:0] MUL_STEPS_COEF = 5'd16;
  localparam logic [4:0] MUL_STEPS_RATE = 5'd19;
  localparam logic [4:0] DIV_STEPS      = 5'd24;

  // One hundred percent, also the divisor of the clamp bounds.
  localparam logic [6:0] PCT_FULL = 7'd100;

  // Saturation bounds of the 40-bit exponential sum, held at 42 bits.
  localparam logic signed [41:0] SUM_MAX = 42'sh07F_FFFF_FFFF;
  localparam logic signed [41:0] SUM_MIN = 42'sh380_0000_0000;

  // Command to the shared serial multiplier.
  typedef struct packed {
    logic              start;
    logic [4:0]        steps;
    logic signed [40:0] mcand;
    logic [18:0]       mplier;
  } mul_cmd_t;

  // Response of the shared serial multiplier: floor(mcand * mplier / 2^steps).
  typedef struct packed {
    logic               done;
    logic signed [41:0] hi;
    logic               sticky;
  } mul_rsp_t;

endpackage

`default_nettype wire

### hdl/avsc_mul_serial.sv
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add multiplier, one multiplier bit per cycle. The upper part of
// the product is kept and shifted right, so after the last step it holds the
// product divided by 2^steps, rounded towards minus infinity. The sticky bit
// records whether any bit shifted out was set.
module avsc_mul_serial (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  avsc_pkg::mul_cmd_t cmd_i,
  output avsc_pkg::mul_rsp_t rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [4:0]         cnt_q;
  logic signed [41:0] hi_q;
  logic signed [40:0] mcand_q;
  logic [18:0]        mplier_q;
  logic               sticky_q;
  logic signed [41:0] add_c;

  // Partial product plus the multiplicand when the current multiplier bit is set.
  always_comb begin
    add_c = hi_q;
    if (mplier_q[0]) begin
      add_c = hi_q + $signed({mcand_q[40], mcand_q});
    end
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: accumulate and shift one bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hi_q     <= '0;
      sticky_q <= 1'b0;
      mcand_q  <= cmd_i.mcand;
      mplier_q <= cmd_i.mplier;
    end else if (busy_q) begin
      hi_q     <= add_c >>> 1;
      sticky_q <= sticky_q | add_c[0];
      mplier_q <= {1'b0, mplier_q[18:1]};
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.hi     = hi_q;
  assign rsp_o.sticky = sticky_q;

endmodule

`default_nettype wire

### hdl/avsc_div100.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring division by one hundred, one quotient bit per cycle. The dividend
// shifts out at the top while the quotient bits shift in at the bottom.
module avsc_div100 (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [23:0] dividend_i,
  output logic [16:0] quot_o
);

  logic [4:0]  cnt_q;
  logic [23:0] x_q;
  logic [6:0]  rem_q;
  logic [7:0]  trial;
  logic        ge;
  logic [7:0]  diff;

  // Trial subtraction of the divisor from the partial remainder.
  always_comb begin
    trial = {rem_q, x_q[23]};
    ge    = trial >= {1'b0, avsc_pkg::PCT_FULL};
    diff  = trial - {1'b0, avsc_pkg::PCT_FULL};
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else if (start_i) begin
      cnt_q <= avsc_pkg::DIV_STEPS;
    end else if (cnt_q != 5'd0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // Remainder and dividend/quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= dividend_i;
      rem_q <= 7'd0;
    end else if (cnt_q != 5'd0) begin
      x_q   <= {x_q[22:0], ge};
      rem_q <= ge ? diff[6:0] : trial[6:0];
    end
  end

  assign quot_o = x_q[16:0];

endmodule

`default_nettype wire

### hdl/av_sync_sample_corrector.sv
`timescale 1ns / 1ps
`default_nettype none

// Audio/video sync sample-count corrector.
// Each input beat is one decoded audio frame: the audio-minus-master clock
// difference (signed Q8.24 seconds), a not-a-number flag and the frame's
// sample count. Each input beat yields exactly one output beat carrying the
// sample count to produce and a flag that says whether a correction applied.
// Both data channels use valid and stall; a beat moves when valid is high and
// stall is low. Registers are written over a separate valid/ready port, which
// is always ready; write them only while the block is idle.
// One frame is processed at a time. When audio is master or the filter resets,
// the frame goes from the check straight to the send state; during warm-up it
// runs the sum update; otherwise the average test follows, and a correction
// adds the rate product. The shared bit-serial multiplier runs 16 steps for the
// sum update, 16 for the average test and 19 for the rate product. Once the
// result is loaded the block returns to idle and takes the next frame.
// The result sits in an output register, so the next frame is accepted while
// the receiver stalls; a finished frame waits in the result register until the
// output register is free. Reset clears the sum, the warm-up count and the
// output, and loads the register defaults; there is no clearing pass.
module av_sync_sample_corrector (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [avsc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [avsc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  signed [31:0]                   clock_diff_i,
  input  wire                                  diff_invalid_i,
  input  wire  [15:0]                          frame_samples_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [16:0]                          wanted_samples_o,
  output logic                                 corrected_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_TEST,
    ST_DELTA,
    ST_SEND
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic        master_q;
  logic [18:0] rate_q;
  logic [15:0] coef_q;
  logic [30:0] thr_q;
  logic [30:0] limit_q;
  logic [6:0]  pct_q;

  // Filter state.
  logic signed [39:0] diff_sum_q;
  logic [4:0]         warmup_q;

  // Captured frame and intermediate values.
  logic signed [31:0] diff_q;
  logic               invalid_q;
  logic [15:0]        n_q;
  logic [40:0]        smag_q;

  // Result and output registers.
  logic [16:0] res_q;
  logic        res_corr_q;
  logic        out_valid_q;
  logic [16:0] wanted_q;
  logic        corrected_q;

  avsc_pkg::mul_cmd_t mul_cmd;
  avsc_pkg::mul_rsp_t mul_rsp;

  logic               div_start;
  logic [16:0]        floor_lo;
  logic [16:0]        floor_hi;
  logic [6:0]         p_sat;
  logic [23:0]        lo_prod;
  logic [23:0]        hi_prod;

  logic [32:0]        diff_ext;
  logic [32:0]        diff_mag;
  logic               too_big;
  logic               do_filter;
  logic signed [41:0] sum_raw;
  logic signed [41:0] sum_clip;
  logic [39:0]        sum_sat;
  logic [40:0]        sum_ext;
  logic [40:0]        s_mag;
  logic [41:0]        ceil_q;
  logic [41:0]        avg;
  logic               pass;
  logic [26:0]        dmag;
  logic signed [27:0] delta;
  logic signed [27:0] wanted_w;
  logic [16:0]        clipped;

  // Configuration writes; indices beyond the list are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= avsc_pkg::RST_AUDIO_IS_MASTER;
      rate_q   <= avsc_pkg::RST_SOURCE_RATE;
      coef_q   <= avsc_pkg::RST_AVG_COEF;
      thr_q    <= avsc_pkg::RST_DIFF_THRESHOLD;
      limit_q  <= avsc_pkg::RST_NO_SYNC_LIMIT;
      pct_q    <= avsc_pkg::RST_CORRECTION_PERCENT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        avsc_pkg::CFG_AUDIO_IS_MASTER:    master_q <= cfg_data_i[0];
        avsc_pkg::CFG_SOURCE_RATE:        rate_q   <= cfg_data_i[18:0];
        avsc_pkg::CFG_AVG_COEF:           coef_q   <= cfg_data_i[15:0];
        avsc_pkg::CFG_DIFF_THRESHOLD:     thr_q    <= cfg_data_i[30:0];
        avsc_pkg::CFG_NO_SYNC_LIMIT:      limit_q  <= cfg_data_i[30:0];
        avsc_pkg::CFG_CORRECTION_PERCENT: pct_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Magnitude of the difference and the filter reset test.
  always_comb begin
    diff_ext  = {diff_q[31], diff_q};
    diff_mag  = diff_q[31] ? (33'd0 - diff_ext) : diff_ext;
    too_big   = invalid_q || (diff_mag >= {2'b00, limit_q});
    do_filter = !master_q && !too_big;
  end

  // New sum: difference plus the floored coefficient product, saturated.
  always_comb begin
    sum_raw = $signed({{10{diff_q[31]}}, diff_q}) + mul_rsp.hi;
    if (sum_raw > avsc_pkg::SUM_MAX) begin
      sum_clip = avsc_pkg::SUM_MAX;
    end else if (sum_raw < avsc_pkg::SUM_MIN) begin
      sum_clip = avsc_pkg::SUM_MIN;
    end else begin
      sum_clip = sum_raw;
    end
    sum_sat = sum_clip[39:0];
    sum_ext = {sum_sat[39], sum_sat};
    s_mag   = sum_sat[39] ? (41'd0 - sum_ext) : sum_ext;
  end

  // Average test: |sum|*(1-c) >= threshold, as |sum| - ceil(|sum|*c) >= threshold.
  always_comb begin
    ceil_q = mul_rsp.hi + {41'd0, mul_rsp.sticky};
    avg    = {1'b0, smag_q} - ceil_q;
    pass   = avg >= {11'd0, thr_q};
  end

  // Correction: rate product truncated towards zero, then clamped.
  always_comb begin
    dmag     = mul_rsp.hi[31:5];
    delta    = diff_q[31] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    wanted_w = $signed({12'd0, n_q}) + delta;
    if (wanted_w < $signed({11'd0, floor_lo})) begin
      clipped = floor_lo;
    end else if (wanted_w > $signed({11'd0, floor_hi})) begin
      clipped = floor_hi;
    end else begin
      clipped = wanted_w[16:0];
    end
  end

  // Clamp bounds: count times (100 -/+ percent), divided by a hundred.
  always_comb begin
    p_sat   = (pct_q > avsc_pkg::PCT_FULL) ? avsc_pkg::PCT_FULL : pct_q;
    lo_prod = 24'(n_q) * 24'(avsc_pkg::PCT_FULL - p_sat);
    hi_prod = 24'(n_q) * 24'({1'b0, avsc_pkg::PCT_FULL} + {1'b0, p_sat});
  end

  // The dividers start with the filter and finish well before the rate product.
  assign div_start = (state_q == ST_CHECK) && do_filter;

  avsc_div100 u_div_lo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lo_prod),
    .quot_o     (floor_lo)
  );

  avsc_div100 u_div_hi (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (hi_prod),
    .quot_o     (floor_hi)
  );

  // Multiplier commands for the three products of a frame.
  always_comb begin
    mul_cmd.start  = 1'b0;
    mul_cmd.steps  = avsc_pkg::MUL_STEPS_COEF;
    mul_cmd.mcand  = $signed({diff_sum_q[39], diff_sum_q});
    mul_cmd.mplier = {3'd0, coef_q};
    case (state_q)
      ST_CHECK: begin
        mul_cmd.start = do_filter;
      end
      ST_SUM: begin
        mul_cmd.start = mul_rsp.done && (warmup_q >= avsc_pkg::AVG_WARMUP);
        mul_cmd.mcand = $signed(s_mag);
      end
      ST_TEST: begin
        mul_cmd.start  = mul_rsp.done && pass;
        mul_cmd.steps  = avsc_pkg::MUL_STEPS_RATE;
        mul_cmd.mcand  = $signed({8'd0, diff_mag});
        mul_cmd.mplier = rate_q;
      end
      default: ;
    endcase
  end

  avsc_mul_serial u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .rsp_o  (mul_rsp)
  );

  // Frame capture and the sum magnitude for the average test.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      diff_q    <= clock_diff_i;
      invalid_q <= diff_invalid_i;
      n_q       <= frame_samples_i;
    end
    if ((state_q == ST_SUM) && mul_rsp.done) begin
      smag_q <= s_mag;
    end
  end

  // Sequencer, filter state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      diff_sum_q  <= '0;
      warmup_q    <= 5'd0;
      res_q       <= 17'd0;
      res_corr_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wanted_q    <= 17'd0;
      corrected_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_SEND)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          res_q      <= {1'b0, n_q};
          res_corr_q <= 1'b0;
          if (master_q) begin
            state_q <= ST_SEND;
          end else if (too_big) begin
            diff_sum_q <= '0;
            warmup_q   <= 5'd0;
            state_q    <= ST_SEND;
          end else begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (mul_rsp.done) begin
            diff_sum_q <= $signed(sum_sat);
            if (warmup_q < avsc_pkg::AVG_WARMUP) begin
              warmup_q <= warmup_q + 5'd1;
              state_q  <= ST_SEND;
            end else begin
              state_q <= ST_TEST;
            end
          end
        end
        ST_TEST: begin
          if (mul_rsp.done) begin
            state_q <= pass ? ST_DELTA : ST_SEND;
          end
        end
        ST_DELTA: begin
          if (mul_rsp.done) begin
            res_q      <= clipped;
            res_corr_q <= 1'b1;
            state_q    <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            wanted_q    <= res_q;
            corrected_q <= res_corr_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign wanted_samples_o = wanted_q;
  assign corrected_o      = corrected_q;

endmodule

`default_nettype wire

### hdl/avsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks of the corrector's sequencing.
module avsc_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_stall_o,
  input wire                             out_valid_o,
  input wire                             out_stall_i,
  input wire [16:0]                      wanted_samples_o,
  input wire                             corrected_o
);

  // Only one frame is in flight: an accepted beat moves the block out of idle, which stalls the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(wanted_samples_o) && $stable(corrected_o)))
    else $error("stalled output beat changed");

  // A result is loaded only as the block returns to idle.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("output valid rose while a frame was still in progress");

  // After a result is taken, valid stays high only if a fresh result was loaded.
  a_reload_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (!out_valid_o || !in_stall_o))
    else $error("output valid held after the beat was taken");

endmodule

bind av_sync_sample_corrector avsc_checker u_avsc_checker (.*);

`default_nettype wire
